// ----- hdl/minifloat_register_alu_core_macros.svh -----
// assertion macros shared by the minifloat register alu rtl
// expects signals clk and rst in the scope where a macro is used
`ifndef MINIFLOAT_REGISTER_ALU_CORE_MACROS_SVH
`define MINIFLOAT_REGISTER_ALU_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define MRALU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MRALU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mralu_pkg.sv -----
// types, constants and helper functions of the minifloat register alu
// no dependencies
package mralu_pkg;

  // register file geometry
  localparam int REG_COUNT = 16;
  localparam int IDX_W     = $clog2(REG_COUNT);
  localparam int DATA_W    = 8;

  // saturated minifloat magnitude
  localparam logic [6:0] SAT_MAG = 7'h7F;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_INT_ADD   = 2'd1,
    OP_FLOAT_ADD = 2'd2,
    OP_READ      = 2'd3
  } opcode_t;

  // minifloat adder result
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              overflow;
  } fadd_res_t;

  // reduce a 4-bit raw index modulo the register count
  function automatic logic [IDX_W-1:0] reg_index(input logic [3:0] raw);
    logic [4:0] v;
    v = {1'b0, raw};
    for (int i = 0; i < 8; i++) begin
      if ((REG_COUNT < 32) && (v >= 5'(REG_COUNT))) begin
        v = v - 5'(REG_COUNT);
      end
    end
    return IDX_W'(v);
  endfunction

endpackage

// ----- hdl/mralu_req_if.sv -----
// request channel: one instruction per beat
// no dependencies
interface mralu_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] source_a_index;
  logic [3:0] source_b_index;
  logic [3:0] dest_index;
  logic [7:0] write_value;

  modport source (
    output valid, opcode, source_a_index, source_b_index, dest_index, write_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, source_a_index, source_b_index, dest_index, write_value,
    output ready
  );
endinterface

// ----- hdl/mralu_rsp_if.sv -----
// response channel: one register update per beat
// no dependencies
interface mralu_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] written_index;
  logic [7:0] written_value;
  logic       float_overflow;

  modport source (
    output valid, written_index, written_value, float_overflow,
    input  ready
  );
  modport sink (
    input  valid, written_index, written_value, float_overflow,
    output ready
  );
endinterface

// ----- hdl/mralu_ram.sv -----
// generic ram: one write port, two read ports with registered read data
// no dependencies
module mralu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, old data on a same-edge write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- hdl/mralu_fadd.sv -----
// minifloat adder: exact fixed-point sum, truncating normalize, saturation
// depends on mralu_pkg
module mralu_fadd import mralu_pkg::*; (
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output fadd_res_t         res
);

  logic [10:0] mag_a;
  logic [10:0] mag_b;
  logic [11:0] mag;
  logic        sign;
  logic [3:0]  top;
  logic [2:0]  exp_out;
  logic [10:0] shifted;

  // operands as 11-bit unsigned fixed point with no fraction bits: mantissa shifted by exponent
  assign mag_a = 11'(a[3:0]) << a[6:4];
  assign mag_b = 11'(b[3:0]) << b[6:4];

  // sign-magnitude sum
  always_comb begin
    if (a[7] == b[7]) begin
      mag  = {1'b0, mag_a} + {1'b0, mag_b};
      sign = a[7];
    end else if (mag_a >= mag_b) begin
      mag  = {1'b0, mag_a - mag_b};
      sign = a[7];
    end else begin
      mag  = {1'b0, mag_b - mag_a};
      sign = b[7];
    end
  end

  // leading one position
  always_comb begin
    top = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (mag[i]) begin
        top = 4'(i);
      end
    end
  end

  // exponent and truncated mantissa
  assign exp_out = (top > 4'd3) ? 3'(top - 4'd3) : 3'd0;
  assign shifted = mag[10:0] >> exp_out;

  // zero, saturation or normal encode
  always_comb begin
    if (mag == 12'd0) begin
      res.value    = '0;
      res.overflow = 1'b0;
    end else if (mag[11]) begin
      res.value    = {sign, SAT_MAG};
      res.overflow = 1'b1;
    end else begin
      res.value    = {sign, exp_out, shifted[3:0]};
      res.overflow = 1'b0;
    end
  end

endmodule

// ----- hdl/minifloat_register_alu_core.sv -----
// top level of the minifloat register alu: register file, execute stage,
// output register; depends on mralu_pkg, mralu_req_if, mralu_rsp_if,
// mralu_ram, mralu_fadd and the assertion macro header
//
// usage
//   req carries one instruction per beat: write a register, add two
//   registers as bytes, add them as minifloats, or read one back (opcode 3).
//   rsp returns one beat per instruction: the register index written and
//   the byte now held there, plus the minifloat saturation flag.
// pipeline and throughput
//   a result passes through the execute stage and the output register
//   before it is presented on rsp. while rsp takes every beat, one
//   instruction per cycle is sustained; the register file read in the
//   accept cycle and a one-entry write bypass let back-to-back dependent
//   instructions issue without bubbles.
// reset
//   rst clears the pipeline and the per-register valid bits, so every
//   register reads as zero until written; no clearing pass is needed.
// stalls
//   when rsp is not taken the result waits in the output register while
//   one more instruction moves into the execute stage; req.ready then
//   drops until the output register drains.
`include "minifloat_register_alu_core_macros.svh"

module minifloat_register_alu_core import mralu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mralu_req_if.sink  req,
  mralu_rsp_if.source rsp
);

  // execute stage
  logic              s1_valid;
  opcode_t           s1_op;
  logic [IDX_W-1:0]  s1_dest;
  logic [DATA_W-1:0] s1_wval;
  logic [IDX_W-1:0]  s1_raddr_a;
  logic [IDX_W-1:0]  s1_raddr_b;
  logic              s1_vld_a;
  logic              s1_vld_b;
  logic              s1_adv;

  // register file support
  logic [REG_COUNT-1:0] valid_bits;
  logic                 byp_valid;
  logic [IDX_W-1:0]     byp_addr;
  logic [DATA_W-1:0]    byp_data;
  logic [DATA_W-1:0]    rdata_a;
  logic [DATA_W-1:0]    rdata_b;

  // output register
  logic              out_valid;
  logic [IDX_W-1:0]  out_index;
  logic [DATA_W-1:0] out_value;
  logic              out_ovf;

  logic              accept;
  opcode_t           req_op;
  logic [IDX_W-1:0]  req_a;
  logic [IDX_W-1:0]  req_b;
  logic [IDX_W-1:0]  req_d;
  logic [IDX_W-1:0]  raddr_a;

  logic [DATA_W-1:0] opnd_a;
  logic [DATA_W-1:0] opnd_b;
  logic [DATA_W-1:0] result;
  logic              result_ovf;
  logic              wr_en;
  fadd_res_t         fres;

  // handshake and index decode
  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign accept    = req.valid && req.ready;
  assign req_op    = opcode_t'(req.opcode);
  assign req_a     = reg_index(req.source_a_index);
  assign req_b     = reg_index(req.source_b_index);
  assign req_d     = reg_index(req.dest_index);
  // a read-back uses port a on the destination
  assign raddr_a   = (req_op == OP_READ) ? req_d : req_a;

  mralu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (REG_COUNT)
  ) u_regfile (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (s1_dest),
    .wdata   (result),
    .re      (accept),
    .raddr_a (raddr_a),
    .raddr_b (req_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // execute stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  // execute stage payload, captured with the ram read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op      <= req_op;
      s1_dest    <= req_d;
      s1_wval    <= req.write_value;
      s1_raddr_a <= raddr_a;
      s1_raddr_b <= req_b;
      s1_vld_a   <= valid_bits[raddr_a];
      s1_vld_b   <= valid_bits[req_b];
    end
  end

  // operand select: latest write, else ram, else reset value
  always_comb begin
    if (byp_valid && (byp_addr == s1_raddr_a)) begin
      opnd_a = byp_data;
    end else begin
      opnd_a = s1_vld_a ? rdata_a : '0;
    end
    if (byp_valid && (byp_addr == s1_raddr_b)) begin
      opnd_b = byp_data;
    end else begin
      opnd_b = s1_vld_b ? rdata_b : '0;
    end
  end

  mralu_fadd u_fadd (
    .a   (opnd_a),
    .b   (opnd_b),
    .res (fres)
  );

  // result select
  always_comb begin
    result_ovf = 1'b0;
    unique case (s1_op)
      OP_WRITE:     result = s1_wval;
      OP_INT_ADD:   result = opnd_a + opnd_b;
      OP_FLOAT_ADD: begin
        result     = fres.value;
        result_ovf = fres.overflow;
      end
      OP_READ:      result = opnd_a;
      default:      result = opnd_a;
    endcase
  end

  assign wr_en = s1_adv && (s1_op != OP_READ);

  // valid bits and write bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      byp_valid  <= 1'b0;
    end else if (wr_en) begin
      valid_bits[s1_dest] <= 1'b1;
      byp_valid           <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byp_addr <= s1_dest;
      byp_data <= result;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_index <= s1_dest;
      out_value <= result;
      out_ovf   <= result_ovf;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.written_index  = 4'(out_index);
  assign rsp.written_value  = out_value;
  assign rsp.float_overflow = out_ovf;

  // checks
  `MRALU_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid,
    "accepted beat did not reach the execute stage")
  `MRALU_ASSERT_NEXT(a_bypass_tracks_write, wr_en,
    byp_valid && (byp_addr == $past(s1_dest)) && (byp_data == $past(result)),
    "write bypass does not hold the last register write")
  `MRALU_ASSERT_NEXT(a_write_sets_valid, wr_en, valid_bits[$past(s1_dest)],
    "written register not marked valid")
  `MRALU_ASSERT_NOW(a_overflow_saturates, out_valid && out_ovf,
    out_value[6:0] == SAT_MAG,
    "overflow flag without saturated magnitude")

endmodule

// ----- verif/minifloat_register_alu_core_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for minifloat_register_alu_core: shadow register file,
// directed corner instructions, then random bursts under random response stalls
// depends on mralu_pkg, mralu_req_if, mralu_rsp_if and the rtl top level
module minifloat_register_alu_core_tb;
  import mralu_pkg::*;

  localparam int RANDOM_INSTRS = 1280;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTED   = 40;

  typedef struct {
    opcode_t    op;
    logic [3:0] src_a;
    logic [3:0] src_b;
    logic [3:0] dest;
    logic [7:0] wdata;
  } alu_instr_t;

  typedef struct {
    logic [3:0] index;
    logic [7:0] value;
    logic       overflow;
  } reg_update_t;

  // shadow copy of the register file and the updates still owed by the dut
  class alu_regfile_shadow;
    logic [7:0]  regs [REG_COUNT];
    reg_update_t pending_updates[$];
    int mismatch_count;
    int n_write, n_int, n_float, n_read, n_saturated, n_float_zero, n_checked;

    function new();
      foreach (regs[i]) regs[i] = 8'h00;
    endfunction

    // exact signed fixed-point sum, then truncating normalization
    function logic [7:0] minifloat_sum(input logic [7:0] x, input logic [7:0] y,
                                       output logic ovf);
      int fx, fy, total, mag, top, e;
      logic sgn;
      fx = int'(x[3:0]) << x[6:4];
      if (x[7]) fx = -fx;
      fy = int'(y[3:0]) << y[6:4];
      if (y[7]) fy = -fy;
      total = fx + fy;
      sgn = (total < 0);
      mag = sgn ? -total : total;
      ovf = 1'b0;
      if (mag == 0) return 8'h00;
      if (mag >= 2048) begin
        ovf = 1'b1;
        return {sgn, SAT_MAG};
      end
      top = 0;
      for (int t = mag; t > 1; t = t >> 1) top++;
      e = (top > 3) ? top - 3 : 0;
      return {sgn, 3'(e), 4'(mag >> e)};
    endfunction

    task report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // accepted request beat: update the shadow file and queue the expected update
    function void note_instruction(input opcode_t op, input logic [3:0] a,
                                   input logic [3:0] b, input logic [3:0] d,
                                   input logic [7:0] wdata);
      int ia, ib, id;
      logic ovf;
      reg_update_t upd;
      ia = int'(a) % REG_COUNT;
      ib = int'(b) % REG_COUNT;
      id = int'(d) % REG_COUNT;
      ovf = 1'b0;
      case (op)
        OP_WRITE: begin
          regs[id] = wdata;
          n_write++;
        end
        OP_INT_ADD: begin
          regs[id] = regs[ia] + regs[ib];
          n_int++;
        end
        OP_FLOAT_ADD: begin
          regs[id] = minifloat_sum(regs[ia], regs[ib], ovf);
          n_float++;
          if (ovf) n_saturated++;
          if (regs[id] == 8'h00) n_float_zero++;
        end
        default: begin
          n_read++;
        end
      endcase
      upd.index    = 4'(id);
      upd.value    = regs[id];
      upd.overflow = ovf;
      pending_updates.push_back(upd);
    endfunction

    // accepted response beat: compare with the oldest expected update
    task check_update(input logic [3:0] idx, input logic [7:0] val, input logic ovf);
      reg_update_t want;
      if (pending_updates.size() == 0) begin
        report_mismatch($sformatf("unexpected update idx %0d val %02h ovf %b", idx, val, ovf));
      end else begin
        want = pending_updates.pop_front();
        n_checked++;
        if (idx !== want.index || val !== want.value || ovf !== want.overflow) begin
          report_mismatch($sformatf("update %0d: got idx %0d val %02h ovf %b, want idx %0d val %02h ovf %b",
                                    n_checked, idx, val, ovf,
                                    want.index, want.value, want.overflow));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst;
  int   cycle_count;

  mralu_req_if req_ch ();
  mralu_rsp_if rsp_ch ();

  alu_regfile_shadow shadow;

  minifloat_register_alu_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // clock and cycle count
  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // monitor both channels at the clock edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        shadow.note_instruction(opcode_t'(req_ch.opcode), req_ch.source_a_index,
                                req_ch.source_b_index, req_ch.dest_index,
                                req_ch.write_value);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        shadow.check_update(rsp_ch.written_index, rsp_ch.written_value,
                            rsp_ch.float_overflow);
      end
    end
  end

  // response stalls: modes of random length, always ready, rotating pattern or heavy stall
  logic [15:0] stall_pattern = 16'hFFFF;
  int          stall_mode    = 0;
  int          mode_left     = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode    <= $urandom_range(0, 2);
      mode_left     <= $urandom_range(20, 120);
      stall_pattern <= 16'($urandom);
    end else begin
      mode_left     <= mode_left - 1;
      stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
    end
    case (stall_mode)
      0: begin
        rsp_ch.ready <= 1'b1;
      end
      1: begin
        rsp_ch.ready <= stall_pattern[0];
      end
      default: begin
        rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // hold one instruction on the request channel until it is taken
  task automatic send_instr(input alu_instr_t ins);
    req_ch.valid          <= 1'b1;
    req_ch.opcode         <= ins.op;
    req_ch.source_a_index <= ins.src_a;
    req_ch.source_b_index <= ins.src_b;
    req_ch.dest_index     <= ins.dest;
    req_ch.write_value    <= ins.wdata;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every outstanding update has come back; the first edge
  // lets the monitor note the last accepted beat
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (shadow.pending_updates.size() != 0);
  endtask

  function automatic alu_instr_t make_instr(input opcode_t op, input int a, input int b,
                                            input int d, input logic [7:0] wdata);
    alu_instr_t ins;
    ins.op    = op;
    ins.src_a = 4'(a);
    ins.src_b = 4'(b);
    ins.dest  = 4'(d);
    ins.wdata = wdata;
    return ins;
  endfunction

  // random instruction, mostly arithmetic; writes favor values that stress the float adder
  function automatic alu_instr_t random_instr();
    alu_instr_t ins;
    int pick;
    logic [7:0] src;
    pick      = $urandom_range(0, 99);
    ins.src_a = 4'($urandom_range(0, 15));
    ins.src_b = 4'($urandom_range(0, 15));
    ins.dest  = 4'($urandom_range(0, 15));
    ins.wdata = 8'($urandom_range(0, 255));
    if (pick < 25)      ins.op = OP_WRITE;
    else if (pick < 55) ins.op = OP_INT_ADD;
    else if (pick < 92) ins.op = OP_FLOAT_ADD;
    else                ins.op = OP_READ;
    if (ins.op == OP_WRITE) begin
      src = shadow.regs[int'(ins.src_a) % REG_COUNT];
      case ($urandom_range(0, 7))
        // negated copy of another register, so later adds can cancel
        0: ins.wdata = {~src[7], src[6:0]};
        // exponent zero, unnormalized range
        1: ins.wdata = {1'($urandom_range(0, 1)), 3'd0, 4'($urandom_range(0, 15))};
        // largest magnitude either sign
        2: ins.wdata = {1'($urandom_range(0, 1)), SAT_MAG};
        default: ;
      endcase
    end
    return ins;
  endfunction

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d updates outstanding",
             cycle_count, shadow.pending_updates.size());
    $display("** minifloat_register_alu_core: FAILED **");
    $finish;
  end

  // stimulus and end of run
  initial begin
    alu_instr_t directed[$];
    int sent;
    int burst;
    shadow                = new();
    cycle_count           = 0;
    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.opcode         = OP_WRITE;
    req_ch.source_a_index = 4'd0;
    req_ch.source_b_index = 4'd0;
    req_ch.dest_index     = 4'd0;
    req_ch.write_value    = 8'h00;
    rsp_ch.ready          = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // corner instructions, every destination index used once or more
    directed.push_back(make_instr(OP_READ,       3,  9,  0, 8'hA5));  // read of a cleared register
    directed.push_back(make_instr(OP_FLOAT_ADD,  0,  0,  1, 8'h00));  // zero plus zero
    directed.push_back(make_instr(OP_WRITE,      0,  0,  2, 8'h7F));
    directed.push_back(make_instr(OP_WRITE,      0,  0,  3, 8'hFF));
    directed.push_back(make_instr(OP_WRITE,      0,  0,  4, 8'h80));  // negative zero
    directed.push_back(make_instr(OP_WRITE,      0,  0, 15, 8'h01));
    directed.push_back(make_instr(OP_FLOAT_ADD,  2,  2,  5, 8'h00));  // positive saturation
    directed.push_back(make_instr(OP_FLOAT_ADD,  3,  3,  6, 8'h00));  // negative saturation
    directed.push_back(make_instr(OP_FLOAT_ADD,  2,  3,  7, 8'h00));  // exact cancellation
    directed.push_back(make_instr(OP_INT_ADD,    2, 15,  8, 8'h00));  // wraps into the sign bit
    directed.push_back(make_instr(OP_INT_ADD,    3, 15,  9, 8'h00));  // wraps to zero
    directed.push_back(make_instr(OP_FLOAT_ADD, 15,  4, 10, 8'h00));  // tiny unnormalized result
    directed.push_back(make_instr(OP_WRITE,      0,  0, 11, 8'h0F));
    directed.push_back(make_instr(OP_FLOAT_ADD, 11, 15, 12, 8'h00));  // carries into normal range
    directed.push_back(make_instr(OP_WRITE,      0,  0, 13, 8'h70));  // top exponent, zero mantissa
    directed.push_back(make_instr(OP_FLOAT_ADD, 13,  4, 14, 8'h00));  // two zero encodings
    directed.push_back(make_instr(OP_WRITE,      0,  0,  0, 8'hC9));
    directed.push_back(make_instr(OP_FLOAT_ADD,  0, 11,  1, 8'h00));  // mixed signs, truncation
    directed.push_back(make_instr(OP_READ,      15, 15,  1, 8'hFF));  // read-back reports dest
    directed.push_back(make_instr(OP_FLOAT_ADD,  2, 11,  2, 8'h00));  // just below saturation
    directed.push_back(make_instr(OP_WRITE,      0,  0,  7, 8'h3A));
    directed.push_back(make_instr(OP_FLOAT_ADD,  7,  7,  7, 8'h00));  // dest is both sources
    directed.push_back(make_instr(OP_INT_ADD,    5,  5,  5, 8'h00));  // feeds the next read-back
    directed.push_back(make_instr(OP_READ,       0,  0,  5, 8'h00));
    foreach (directed[i]) send_instr(directed[i]);
    wait_for_drain();

    // random bursts with random gaps, one full drain halfway
    sent = 0;
    while (sent < RANDOM_INSTRS) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 30);
      for (int k = 0; k < burst && sent < RANDOM_INSTRS; k++) begin
        send_instr(random_instr());
        sent++;
        if (sent == RANDOM_INSTRS / 2) wait_for_drain();
      end
      idle_gap($urandom_range(1, 8));
    end

    // let everything come back, then watch a little longer for strays
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d instructions in %0d cycles: %0d writes, %0d byte adds, %0d reads",
             shadow.n_checked, cycle_count, shadow.n_write, shadow.n_int, shadow.n_read);
    $display("minifloat adds: %0d, of which %0d saturated and %0d gave zero",
             shadow.n_float, shadow.n_saturated, shadow.n_float_zero);
    if (shadow.mismatch_count == 0) begin
      $display("** minifloat_register_alu_core: PASSED **");
    end else begin
      $display("%0d mismatches", shadow.mismatch_count);
      $display("** minifloat_register_alu_core: FAILED **");
    end
    $finish;
  end

endmodule
